// File: hw/rtl/spd_pkg.sv
// Shared types and constants for the sound presence detector.
`default_nettype none

package spd_pkg;

   localparam int BLOCK_LEN = 1000;

   localparam int SAMPLE_W = 12;
   localparam int CNT_W = 16;
   localparam int SUM_W = 23;
   localparam int IDX_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_DATA_W-1:0] LEVEL_THRESHOLD_RESET = 16'd517;
   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_LENGTH_RESET = 16'd8;
   localparam logic [CSR_DATA_W-1:0] HOLD_LENGTH_RESET = 16'd500;
   localparam logic [CSR_DATA_W-1:0] CHIRP_GAP_RESET = 16'd5;

   // The block mean is the total times a rounded-up reciprocal, shifted down.
   // With the shift at SUM_W plus the bit length of BLOCK_LEN the quotient is
   // exact for every total below two to the SUM_W.
   localparam int MEAN_LOG = $clog2(BLOCK_LEN);
   localparam int MEAN_SHIFT = SUM_W + MEAN_LOG;
   localparam int MUL_W = 25;
   localparam int PROD_W = SUM_W + MUL_W;
   localparam logic [MUL_W-1:0] MEAN_MUL =
      MUL_W'(((longint'(1) << MEAN_SHIFT) + longint'(BLOCK_LEN) - 1) /
             longint'(BLOCK_LEN));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL_THRESHOLD = 2'd0,
      CSR_DEBOUNCE_LENGTH = 2'd1,
      CSR_HOLD_LENGTH     = 2'd2,
      CSR_CHIRP_GAP       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                mic_mode;
   } req_type;

   typedef struct packed {
      logic                heard;
      logic                chirp_start;
      logic                mean_valid;
      logic [SAMPLE_W-1:0] block_mean;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] level_threshold;
      logic [7:0]          debounce_length;
      logic [CNT_W-1:0]    hold_length;
      logic [7:0]          chirp_gap;
   } cfg_type;

   typedef struct packed {
      logic             block_end;
      logic [SUM_W-1:0] block_total;
   } accum_type;

   typedef struct packed {
      req_type   req;
      accum_type accum;
   } stage_type;

   typedef struct packed {
      logic heard;
      logic chirp_start;
   } det_type;

endpackage

`default_nettype wire

// File: hw/rtl/spd_ifs.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface spd_req_if;
   logic             valid;
   logic             ready;
   spd_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spd_rsp_if;
   logic             valid;
   logic             ready;
   spd_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sound_presence_detector.sv
// Top level of the sound presence detector.
`default_nettype none

// One result per sample. A request transfer is taken on any cycle in which the
// stage register is empty or moving on, so a sample can enter every cycle while
// results are taken; a result passes through the stage and result registers.
// The running sum is added at the request transfer; detection, the debounce,
// hold and chirp counters and the block mean (one multiplication by a
// reciprocal) are worked out between the stage register and the result
// register. Configuration writes take effect on the following sample and
// should be made while no sample is in flight.
module sound_presence_detector (
   input  wire logic                             clock,
   input  wire logic                             reset,
   spd_req_if.sink                               req_chan,
   spd_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [spd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [spd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   spd_pkg::cfg_type   cfg_ff;
   spd_pkg::stage_type stage_ff;
   logic               stage_valid_ff;
   spd_pkg::rsp_type   rsp_ff;
   spd_pkg::rsp_type   rsp_in;
   logic               rsp_valid_ff;
   spd_pkg::accum_type accum;
   spd_pkg::det_type   det;
   logic [spd_pkg::SAMPLE_W-1:0] mean;
   logic               out_free;
   logic               advance;
   logic               req_ready;
   logic               req_accept;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance = stage_valid_ff && out_free;
   assign req_ready = !stage_valid_ff || out_free;
   assign req_accept = req_chan.valid && req_ready;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_threshold <= spd_pkg::LEVEL_THRESHOLD_RESET[spd_pkg::SAMPLE_W-1:0];
         cfg_ff.debounce_length <= spd_pkg::DEBOUNCE_LENGTH_RESET[7:0];
         cfg_ff.hold_length <= spd_pkg::HOLD_LENGTH_RESET;
         cfg_ff.chirp_gap <= spd_pkg::CHIRP_GAP_RESET[7:0];
      end else if (csr_wr_en) begin
         unique case (spd_pkg::csr_index_type'(csr_index))
            spd_pkg::CSR_LEVEL_THRESHOLD: begin
               cfg_ff.level_threshold <= csr_wdata[spd_pkg::SAMPLE_W-1:0];
            end
            spd_pkg::CSR_DEBOUNCE_LENGTH: begin
               cfg_ff.debounce_length <= csr_wdata[7:0];
            end
            spd_pkg::CSR_HOLD_LENGTH: begin
               cfg_ff.hold_length <= csr_wdata;
            end
            spd_pkg::CSR_CHIRP_GAP: begin
               cfg_ff.chirp_gap <= csr_wdata[7:0];
            end
         endcase
      end
   end

   spd_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .sample (req_chan.data.sample),
      .result (accum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff.req <= req_chan.data;
         stage_ff.accum <= accum;
      end
   end

   spd_detect u_detect (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (advance),
      .req     (stage_ff.req),
      .result  (det)
   );

   spd_mean u_mean (
      .block_end   (stage_ff.accum.block_end),
      .block_total (stage_ff.accum.block_total),
      .block_mean  (mean)
   );

   always_comb begin
      rsp_in.heard = det.heard;
      rsp_in.chirp_start = det.chirp_start;
      rsp_in.mean_valid = stage_ff.accum.block_end;
      rsp_in.block_mean = mean;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/spd_accum.sv
// Block sum accumulator that marks the sample closing each averaging block.
`default_nettype none

module spd_accum (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [spd_pkg::SAMPLE_W-1:0]   sample,
   output spd_pkg::accum_type                  result
);

   logic [spd_pkg::SUM_W-1:0] sum_ff;
   logic [spd_pkg::SUM_W-1:0] sum_in;
   logic [spd_pkg::IDX_W-1:0] idx_ff;
   logic [spd_pkg::IDX_W-1:0] idx_in;
   logic [spd_pkg::SUM_W-1:0] total;
   logic                      last;

   always_comb begin
      total = sum_ff + spd_pkg::SUM_W'(sample);
      last = (idx_ff == spd_pkg::IDX_W'(spd_pkg::BLOCK_LEN - 1));
      sum_in = sum_ff;
      idx_in = idx_ff;
      if (accept) begin
         if (last) begin
            sum_in = '0;
            idx_in = '0;
         end else begin
            sum_in = total;
            idx_in = idx_ff + spd_pkg::IDX_W'(1);
         end
      end
      result.block_end = last;
      result.block_total = total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         idx_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/spd_detect.sv
// Loud-sound detector with debounce, hold and chirp gap counters.
`default_nettype none

module spd_detect (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire spd_pkg::cfg_type  cfg,
   input  wire logic              advance,
   input  wire spd_pkg::req_type  req,
   output spd_pkg::det_type       result
);

   localparam logic [spd_pkg::CNT_W-1:0] CNT_MAX = '1;

   logic [spd_pkg::CNT_W-1:0] loud_ff;
   logic [spd_pkg::CNT_W-1:0] loud_in;
   logic [spd_pkg::CNT_W-1:0] quiet_ff;
   logic [spd_pkg::CNT_W-1:0] quiet_in;
   logic [spd_pkg::CNT_W-1:0] since_ff;
   logic [spd_pkg::CNT_W-1:0] since_in;
   logic                      detected_ff;
   logic                      detected_in;
   logic [spd_pkg::CNT_W-1:0] loud_inc;
   logic [spd_pkg::CNT_W-1:0] quiet_inc;
   logic [spd_pkg::CNT_W-1:0] since_mid;
   logic                      chirp;

   always_comb begin
      loud_inc = (loud_ff == CNT_MAX) ? CNT_MAX : loud_ff + spd_pkg::CNT_W'(1);
      quiet_inc = (quiet_ff == CNT_MAX) ? CNT_MAX : quiet_ff + spd_pkg::CNT_W'(1);
      loud_in = loud_ff;
      quiet_in = quiet_ff;
      since_in = since_ff;
      since_mid = since_ff;
      detected_in = detected_ff;
      chirp = 1'b0;
      if (req.mic_mode) begin
         if (req.sample > cfg.level_threshold) begin
            loud_in = loud_inc;
            if (loud_inc > spd_pkg::CNT_W'(cfg.debounce_length)) begin
               if (!detected_ff && (since_ff >= spd_pkg::CNT_W'(cfg.chirp_gap))) begin
                  chirp = 1'b1;
                  since_mid = '0;
               end
               detected_in = 1'b1;
               quiet_in = '0;
            end
         end else begin
            loud_in = '0;
            if (detected_ff) begin
               quiet_in = quiet_inc;
               if (quiet_inc > cfg.hold_length) begin
                  detected_in = 1'b0;
               end
            end
         end
         since_in = (since_mid == CNT_MAX) ? CNT_MAX : since_mid + spd_pkg::CNT_W'(1);
      end else begin
         detected_in = 1'b0;
      end
      result.heard = detected_in;
      result.chirp_start = chirp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loud_ff <= '0;
         quiet_ff <= '0;
         since_ff <= '0;
         detected_ff <= 1'b0;
      end else if (advance) begin
         loud_ff <= loud_in;
         quiet_ff <= quiet_in;
         since_ff <= since_in;
         detected_ff <= detected_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/spd_mean.sv
// Block mean by reciprocal multiplication of the completed block total.
`default_nettype none

module spd_mean (
   input  wire logic                           block_end,
   input  wire logic [spd_pkg::SUM_W-1:0]      block_total,
   output logic      [spd_pkg::SAMPLE_W-1:0]   block_mean
);

   logic [spd_pkg::PROD_W-1:0] product;

   always_comb begin
      product = spd_pkg::PROD_W'(block_total) * spd_pkg::PROD_W'(spd_pkg::MEAN_MUL);
      block_mean = block_end ? product[spd_pkg::MEAN_SHIFT +: spd_pkg::SAMPLE_W] : '0;
   end

endmodule

`default_nettype wire
